// File: hdl/wbps_pkg.sv
// Shared constants and types of the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int ADDRESS_BITS      = 47;
   localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES - 1;
   localparam int POS_BITS          = $clog2(MAX_PATTERN_BYTES);
   localparam int LENGTH_BITS       = 5;
   localparam int WILD_BITS         = 8;
   localparam int COUNT_BITS        = 22;
   localparam int NUMBER_BITS       = 21;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int PATTERN_WORD_BYTES = CSR_DATA_BITS / 8;

   localparam logic [COUNT_BITS-1:0] LIMIT_CAP = COUNT_BITS'(2097152);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_PATTERN_LEN  = 3'd2,
      CSR_WILDCARD     = 3'd3,
      CSR_MATCH_LIMIT  = 3'd4
   } csr_index_type;

   // Control handed to every window cell in the same cycle.
   typedef struct packed {
      logic advance;
      logic flush;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] match_address;
      logic [NUMBER_BITS-1:0]  match_number;
      logic                    limit_reached;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/wbps_req_if.sv
// Input channel of the scanner: one memory byte per word.
`default_nettype none

interface wbps_req_if import wbps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [7:0]              byte_value;
   logic [ADDRESS_BITS-1:0] byte_address;
   logic                    segment_start;
   logic                    scan_start;

   modport source (output valid, byte_value, byte_address, segment_start, scan_start,
                   input ready);
   modport sink   (input valid, byte_value, byte_address, segment_start, scan_start,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/wbps_rsp_if.sv
// Result channel of the scanner: one reported match per word.
`default_nettype none

interface wbps_rsp_if import wbps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ADDRESS_BITS-1:0] match_address;
   logic [NUMBER_BITS-1:0]  match_number;
   logic                    limit_reached;

   modport source (output valid, match_address, match_number, limit_reached,
                   input ready);
   modport sink   (input valid, match_address, match_number, limit_reached,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner: configuration, window chain and match tally.
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_chan  in         valid / ready         byte_value, byte_address, segment_start, scan_start
// rsp_chan  out        valid / ready         match_address, match_number, limit_reached
// csr_*     in         csr_write_enable      csr_index, csr_write_data (write only)
//
// Every accepted word is compared in the cycle it is accepted, and a match is written to
// the result buffer at that same edge, so one word per cycle is sustained while the skid
// register is empty; the rate is set by the window cell chain shift and the parallel compare.
// A result is visible on rsp_chan in the cycle after its byte is accepted when the output
// register is free or being taken; otherwise it waits in the skid register behind it.
// Synchronous reset empties the window, the match counter and the result buffer, and
// restores the configuration defaults. The input keeps accepting while one result waits;
// it stalls in every cycle in which the skid register is full, even if the output register
// is being taken in that cycle, since ready is driven from the registered skid state alone.

module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   wbps_req_if.sink                       req_chan,
   wbps_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   // Configuration registers.
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [LENGTH_BITS-1:0]   pattern_length_ff;
   logic [WILD_BITS-1:0]     wildcard_ff;
   logic [COUNT_BITS-1:0]    match_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= LENGTH_BITS'(1);
         wildcard_ff       <= '0;
         match_limit_ff    <= LIMIT_CAP;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_write_data[LENGTH_BITS-1:0];
            CSR_WILDCARD:     wildcard_ff       <= csr_write_data[WILD_BITS-1:0];
            CSR_MATCH_LIMIT:  match_limit_ff    <= csr_write_data[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // The length is clamped into one to the window size plus one; the limit to its cap.
   logic [LENGTH_BITS-1:0] length_eff;
   logic [COUNT_BITS-1:0]  limit_eff;

   always_comb begin
      if (pattern_length_ff == '0) begin
         length_eff = LENGTH_BITS'(1);
      end else if (pattern_length_ff > LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
         length_eff = LENGTH_BITS'(MAX_PATTERN_BYTES);
      end else begin
         length_eff = pattern_length_ff;
      end
      limit_eff = (match_limit_ff > LIMIT_CAP) ? LIMIT_CAP : match_limit_ff;
   end

   // Pattern bytes are realigned so that position j back from the current byte meets
   // pattern byte length-1-j; positions at or beyond the length are unused.
   logic [7:0]                   pattern_bytes [MAX_PATTERN_BYTES];
   logic [7:0]                   aligned_byte  [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] position_used;
   logic [LENGTH_BITS-1:0]       pick [MAX_PATTERN_BYTES];

   always_comb begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (i < PATTERN_WORD_BYTES) begin
            pattern_bytes[i] = pattern_low_ff[(i % PATTERN_WORD_BYTES) * 8 +: 8];
         end else begin
            pattern_bytes[i] = pattern_high_ff[(i % PATTERN_WORD_BYTES) * 8 +: 8];
         end
      end
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         position_used[j] = LENGTH_BITS'(j) < length_eff;
         pick[j]          = length_eff - LENGTH_BITS'(1) - LENGTH_BITS'(j);
         aligned_byte[j]  = pattern_bytes[pick[j][POS_BITS-1:0]];
      end
   end

   // Handshake and window control.
   logic          can_accept;
   logic          fire;
   logic          clear_window;
   cell_ctrl_type cell_ctrl;

   assign req_chan.ready = can_accept;
   assign fire           = req_chan.valid && can_accept;
   assign clear_window   = req_chan.segment_start || req_chan.scan_start;

   assign cell_ctrl.advance = fire;
   assign cell_ctrl.flush   = fire && clear_window;

   // Window cell chain: cell k holds the byte k+1 words back in the current span.
   logic [7:0]              held_byte  [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] held_valid;
   logic [WINDOW_DEPTH-1:0] cell_hit;
   logic [7:0]              link_byte  [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] link_valid;

   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign link_byte[k]  = req_chan.byte_value;
         assign link_valid[k] = 1'b1;
      end else begin : g_body
         assign link_byte[k]  = held_byte[k-1];
         assign link_valid[k] = held_valid[k-1] && !cell_ctrl.flush;
      end

      wbps_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .prev_byte      (link_byte[k]),
         .prev_valid     (link_valid[k]),
         .pattern_byte   (aligned_byte[k+1]),
         .wildcard_value (wildcard_ff),
         .used           (position_used[k+1]),
         .held_byte      (held_byte[k]),
         .held_valid     (held_valid[k]),
         .hit            (cell_hit[k])
      );
   end

   // The current byte always takes the last pattern position.
   logic current_hit;
   logic full_hit;

   assign current_hit = (aligned_byte[0] == wildcard_ff)
                        || (req_chan.byte_value == aligned_byte[0]);
   assign full_hit    = current_hit && (&cell_hit);

   // Match tally: a new scan restarts the count before this word is judged.
   logic [COUNT_BITS-1:0] match_counter_ff;
   logic [COUNT_BITS-1:0] match_counter_in;
   logic [COUNT_BITS-1:0] counter_eff;
   logic [COUNT_BITS-1:0] counter_next;
   logic                  push;
   result_type            push_data;

   always_comb begin
      counter_eff  = req_chan.scan_start ? '0 : match_counter_ff;
      counter_next = counter_eff + COUNT_BITS'(1);
      push         = fire && full_hit && (counter_eff < limit_eff);

      match_counter_in = match_counter_ff;
      if (fire) begin
         match_counter_in = push ? counter_next : counter_eff;
      end

      push_data.match_address = req_chan.byte_address
                                - ADDRESS_BITS'(length_eff - LENGTH_BITS'(1));
      push_data.match_number  = counter_eff[NUMBER_BITS-1:0];
      push_data.limit_reached = (counter_next == limit_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_counter_ff <= '0;
      end else begin
         match_counter_ff <= match_counter_in;
      end
   end

   wbps_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );

   a_counter_capped: assert property (@(posedge clock) disable iff (reset)
      match_counter_ff <= LIMIT_CAP)
      else $error("match counter beyond the limit cap");

   a_counter_steps: assert property (@(posedge clock) disable iff (reset)
      push |=> (match_counter_ff == $past(counter_next)))
      else $error("match counter did not advance with a reported match");

   a_zero_limit_silent: assert property (@(posedge clock) disable iff (reset)
      (limit_eff == '0) |-> !push)
      else $error("match reported with a zero match limit");

   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      (fire && req_chan.scan_start && !push) |=> (match_counter_ff == '0))
      else $error("scan start did not clear the match counter");

endmodule

`default_nettype wire

// File: hdl/wbps_cell.sv
// One window cell: holds a past byte and compares it with its aligned pattern byte.
`default_nettype none

module wbps_cell import wbps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [7:0]           prev_byte,
   input  wire logic                 prev_valid,
   input  wire logic [7:0]           pattern_byte,
   input  wire logic [WILD_BITS-1:0] wildcard_value,
   input  wire logic                 used,
   output logic [7:0]                held_byte,
   output logic                      held_valid,
   output logic                      hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       valid_ff;
   logic       valid_in;

   always_comb begin
      byte_in  = ctrl.advance ? prev_byte : byte_ff;
      valid_in = ctrl.advance ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // A flushed window holds nothing, so a used position then fails even on a wildcard.
   assign hit = !used
                || (valid_ff && !ctrl.flush
                    && ((pattern_byte == wildcard_value) || (byte_ff == pattern_byte)));

   assign held_byte  = byte_ff;
   assign held_valid = valid_ff;

endmodule

`default_nettype wire

// File: hdl/wbps_out_buffer.sv
// Two-word result buffer: an output register backed by a skid register.
`default_nettype none

module wbps_out_buffer import wbps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            can_accept,
   wbps_rsp_if.source      rsp_chan
);

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       pop;

   assign pop = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_in) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign can_accept             = !skid_valid_ff;
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.match_address = out_ff.match_address;
   assign rsp_chan.match_number  = out_ff.match_number;
   assign rsp_chan.limit_reached = out_ff.limit_reached;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed while both buffer registers are full");

   a_stalled_word_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result word changed or vanished");

endmodule

`default_nettype wire
